// ===== hdl/i2rs_pkg.sv =====
// Shared types, constants and the digit alphabet for the integer to radix text converter.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package i2rs_pkg;

    localparam int MAG_W   = 63;
    localparam int CHAR_W  = 7;
    localparam int RADIX_W = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 7'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 7'd85;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

    // Quotient bits retired by the divider per cycle
    localparam int DIV_BITS_PER_CYCLE = 8;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } item_t;

    typedef struct packed {
        logic               start;
        logic [MAG_W-1:0]   dividend;
        logic [RADIX_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [MAG_W-1:0]   quotient;
        logic [RADIX_W-1:0] remainder;
    } div_rsp_t;

    // Map a digit (0..84) to its ASCII code:
    // 0-9, a-z, A-Z, then ! through / , then : through @ , then [
    function automatic logic [CHAR_W-1:0] sym_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 7'd10)
            c = 7'h30 + d;
        else if (d < 7'd36)
            c = 7'h57 + d;
        else if (d < 7'd62)
            c = 7'h1d + d;
        else if (d < 7'd77)
            c = 7'h63 + d;
        else if (d < 7'd84)
            c = 7'h6d + d;
        else
            c = 7'h5b;
        return c;
    endfunction

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] b;
        if (r < RADIX_MIN)
            b = RADIX_MIN;
        else if (r > RADIX_MAX)
            b = RADIX_MAX;
        else
            b = r;
        return b;
    endfunction

endpackage

// ===== hdl/i2rs_front.sv =====
// Front end: takes a signed input value, splits off the sign and forms the magnitude.
// Depends on i2rs_pkg.
module i2rs_front (
    input  logic                      start,
    input  logic                      q_full,
    input  logic signed [63:0]        value,
    output logic                      push,
    output i2rs_pkg::item_t           item,
    output logic                      busy
);

    logic [63:0] mag64;

    assign busy  = q_full;
    assign push  = start && !q_full;

    always_comb
    begin
        mag64 = value[63] ? (~value + 64'd1) : value;
        item.neg = value[63];
        // Most negative input overflows the magnitude: saturate
        item.mag = mag64[63] ? {i2rs_pkg::MAG_W{1'b1}} : mag64[i2rs_pkg::MAG_W-1:0];
    end

endmodule

// ===== hdl/i2rs_fifo.sv =====
// Two-entry queue between the front end and the conversion back end.
// Depends on i2rs_pkg.
module i2rs_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  i2rs_pkg::item_t       push_item,
    input  logic                  pop,
    output i2rs_pkg::item_t       head,
    output logic                  empty,
    output logic                  full
);

    i2rs_pkg::item_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ===== hdl/i2rs_div.sv =====
// Iterative divider: 63-bit magnitude by a 7-bit base, several quotient bits per cycle.
// Depends on i2rs_pkg.
module i2rs_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  i2rs_pkg::div_req_t   req,
    output i2rs_pkg::div_rsp_t   rsp
);

    localparam int SH_W    = i2rs_pkg::MAG_W + 1;
    localparam int NSTEP   = SH_W / i2rs_pkg::DIV_BITS_PER_CYCLE;
    localparam int STEP_W  = $clog2(NSTEP);

    logic [SH_W-1:0]              sh_reg, sh_next;
    logic [i2rs_pkg::RADIX_W-1:0] rem_reg, rem_next;
    logic [i2rs_pkg::RADIX_W-1:0] divisor_reg;
    logic [STEP_W-1:0]            step_reg;
    logic                         run_reg;
    logic                         done_reg;

    // Restoring division, one quotient bit per inner step
    always_comb
    begin
        logic [i2rs_pkg::RADIX_W:0] r;
        sh_next  = sh_reg;
        rem_next = rem_reg;
        for (int i = 0; i < i2rs_pkg::DIV_BITS_PER_CYCLE; i++)
        begin
            r       = {rem_next, sh_next[SH_W-1]};
            sh_next = {sh_next[SH_W-2:0], 1'b0};
            if (r >= {1'b0, divisor_reg})
            begin
                r          = r - {1'b0, divisor_reg};
                sh_next[0] = 1'b1;
            end
            rem_next = r[i2rs_pkg::RADIX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            sh_reg      <= {1'b0, req.dividend};
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(NSTEP - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = sh_reg[i2rs_pkg::MAG_W-1:0];
    assign rsp.remainder = rem_reg;

endmodule

// ===== hdl/i2rs_back.sv =====
// Back end: drives the divider, pushes digit characters on a stack, then pops them out
// behind an optional minus sign. Depends on i2rs_pkg and i2rs_div.
module i2rs_back #(
    parameter int DIGIT_STACK_DEPTH = 63
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [i2rs_pkg::RADIX_W-1:0]       radix,
    input  i2rs_pkg::item_t                    head,
    input  logic                               q_empty,
    output logic                               pop,
    output logic                               strobe,
    output logic [i2rs_pkg::CHAR_W-1:0]        character,
    output logic                               last
);

    localparam int CNT_W  = $clog2(DIGIT_STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(DIGIT_STACK_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LEAD,
        ST_SEND
    } state_t;

    state_t                        state_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          neg_reg;
    logic                          strobe_reg;
    logic [i2rs_pkg::CHAR_W-1:0]   character_reg;
    logic                          last_reg;

    logic [i2rs_pkg::CHAR_W-1:0]   stack [DIGIT_STACK_DEPTH];
    logic [i2rs_pkg::CHAR_W-1:0]   rd_data_reg;

    i2rs_pkg::div_req_t            div_req;
    i2rs_pkg::div_rsp_t            div_rsp;

    logic [CNT_W-1:0]              cnt_inc;
    logic                          more_digits;
    logic                          wr_en;
    logic                          rd_en;
    logic [CNT_W-1:0]              rd_idx;

    i2rs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cnt_inc     = cnt_reg + 1'b1;
    assign more_digits = (div_rsp.quotient != '0) && (cnt_inc < CNT_W'(DIGIT_STACK_DEPTH));
    assign pop         = (state_reg == ST_IDLE) && !q_empty;
    assign wr_en       = (state_reg == ST_DIV) && div_rsp.done;

    always_comb
    begin
        div_req.divisor = i2rs_pkg::clamp_radix(radix);
        if (state_reg == ST_IDLE)
        begin
            div_req.start    = !q_empty;
            div_req.dividend = head.mag;
        end
        else
        begin
            div_req.start    = wr_en && more_digits;
            div_req.dividend = div_rsp.quotient;
        end
    end

    // Look one entry ahead while sending so a character leaves every cycle
    always_comb
    begin
        if (state_reg == ST_SEND)
        begin
            rd_idx = cnt_reg - CNT_W'(2);
            rd_en  = (cnt_reg > CNT_W'(1));
        end
        else
        begin
            rd_idx = cnt_reg - CNT_W'(1);
            rd_en  = (state_reg == ST_LEAD);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack[cnt_reg[ADDR_W-1:0]] <= i2rs_pkg::sym_char(div_rsp.remainder);
        if (rd_en)
            rd_data_reg <= stack[rd_idx[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
            strobe_reg    <= 1'b0;
            character_reg <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        neg_reg   <= head.neg;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        cnt_reg <= cnt_inc;
                        if (!more_digits)
                            state_reg <= ST_LEAD;
                    end
                end
                ST_LEAD:
                begin
                    // Minus sign goes out while the top digit is read
                    strobe_reg    <= neg_reg;
                    character_reg <= i2rs_pkg::CHAR_MINUS;
                    last_reg      <= 1'b0;
                    state_reg     <= ST_SEND;
                end
                ST_SEND:
                begin
                    strobe_reg    <= 1'b1;
                    character_reg <= rd_data_reg;
                    last_reg      <= (cnt_reg == CNT_W'(1));
                    cnt_reg       <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign strobe    = strobe_reg;
    assign character = character_reg;
    assign last      = last_reg;

endmodule

// ===== hdl/integer_to_radix_string.sv =====
// Top level of the signed integer to radix text converter: radix register, front end,
// queue and back end. Depends on i2rs_pkg, i2rs_front, i2rs_fifo and i2rs_back.
//
//   channel   ports                        handshake
//   -------   --------------------------   -------------------------------------
//   input     value                        beat taken when start && !busy
//   result    character, last              one beat per cycle with strobe high
//   config    radix_wdata                  written when radix_we is high
//
// Each digit takes one pass of the shared divider (8 quotient bits per cycle over a
// 64-bit shift); the stack takes the digit as the pass completes. After the last
// digit, state ST_LEAD sends the optional minus sign and then one character leaves
// per cycle. Base 2 at full magnitude is the worst case. Reset clears control state
// and sets radix to 10. A two-entry queue takes new values while a conversion runs;
// busy rises only when it is full. Results cannot be stalled.
module integer_to_radix_string #(
    parameter int DIGIT_STACK_DEPTH = 63
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [63:0]                 value,
    input  logic                               radix_we,
    input  logic [i2rs_pkg::RADIX_W-1:0]       radix_wdata,
    output logic                               strobe,
    output logic [i2rs_pkg::CHAR_W-1:0]        character,
    output logic                               last
);

    logic [i2rs_pkg::RADIX_W-1:0] radix_reg;
    logic                         push;
    logic                         pop;
    logic                         q_full;
    logic                         q_empty;
    i2rs_pkg::item_t              push_item;
    i2rs_pkg::item_t              head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= i2rs_pkg::RADIX_RESET;
        else if (radix_we)
            radix_reg <= radix_wdata;
    end

    i2rs_front u_front (
        .start  (start),
        .q_full (q_full),
        .value  (value),
        .push   (push),
        .item   (push_item),
        .busy   (busy)
    );

    i2rs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    i2rs_back #(
        .DIGIT_STACK_DEPTH (DIGIT_STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .radix     (radix_reg),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for integer_to_radix_string: drives signed 64-bit values through
// start/busy, checks every character beat against fixed texts or a local radix conversion. Needs i2rs_pkg.
module testbench;

    localparam int HALF_PERIOD       = 5;
    localparam int DIGIT_STACK_DEPTH = 63;
    localparam int CYCLE_LIMIT       = 1000000;
    localparam int DRAIN_LIMIT       = 20000;
    localparam int PHASES            = 8;
    localparam int PHASE_ITEMS       = 40;
    localparam logic [63:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam bit [85*8-1:0] GLYPHS =
        "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ!\"#$%&'()*+,-./:;<=>?@[";

    typedef struct packed {
        logic [i2rs_pkg::CHAR_W-1:0] code;
        logic                        fin;
    } char_beat_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic signed [63:0]                value = '0;
    logic                              radix_we = 1'b0;
    logic [i2rs_pkg::RADIX_W-1:0]      radix_wdata = '0;
    logic                              strobe;
    logic [i2rs_pkg::CHAR_W-1:0]       character;
    logic                              last;

    char_beat_t                        pending_chars [$];
    logic [i2rs_pkg::RADIX_W-1:0]      radix_now = i2rs_pkg::RADIX_RESET;
    bit                                steady = 1'b0;
    int                                mismatches = 0;
    int                                numbers_sent = 0;
    int                                chars_seen = 0;
    int                                radix_writes = 0;
    int                                cycle_count = 0;

    logic [i2rs_pkg::RADIX_W-1:0]      row_radix [$];
    logic [63:0]                       row_value [$];
    string                             row_text [$];

    integer_to_radix_string #(
        .DIGIT_STACK_DEPTH(DIGIT_STACK_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .value(value),
        .radix_we(radix_we),
        .radix_wdata(radix_wdata),
        .strobe(strobe),
        .character(character),
        .last(last)
    );

    always #HALF_PERIOD clk = ~clk;

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic logic [i2rs_pkg::CHAR_W-1:0] digit_glyph(
        input logic [i2rs_pkg::RADIX_W-1:0] d);
        return GLYPHS[(84 - int'(d)) * 8 +: i2rs_pkg::CHAR_W];
    endfunction

    task automatic queue_char(input logic [i2rs_pkg::CHAR_W-1:0] code, input logic fin);
        char_beat_t beat;
        beat.code = code;
        beat.fin  = fin;
        pending_chars.push_back(beat);
    endtask

    // Divide the magnitude down, collect digits low first, emit them high first
    task automatic predict_text(input logic [63:0] v);
        logic [63:0]                 mag;
        logic [63:0]                 base;
        logic [i2rs_pkg::CHAR_W-1:0] digits [$];
        int                          i;
        base = 64'((radix_now < i2rs_pkg::RADIX_MIN) ? i2rs_pkg::RADIX_MIN :
                   (radix_now > i2rs_pkg::RADIX_MAX) ? i2rs_pkg::RADIX_MAX : radix_now);
        mag = v[63] ? (~v + 64'd1) : v;
        if (mag > MAG_LIMIT)
            mag = MAG_LIMIT;
        do
        begin
            digits.push_back(digit_glyph(i2rs_pkg::RADIX_W'(mag % base)));
            mag = mag / base;
        end while (mag != 0 && digits.size() < DIGIT_STACK_DEPTH);
        if (v[63])
            queue_char(i2rs_pkg::CHAR_MINUS, 1'b0);
        for (i = digits.size() - 1; i >= 0; i--)
            queue_char(digits[i], i == 0);
    endtask

    task automatic add_row(input logic [i2rs_pkg::RADIX_W-1:0] r, input logic [63:0] v,
                           input string t);
        row_radix.push_back(r);
        row_value.push_back(v);
        row_text.push_back(t);
    endtask

    // Empty text means the expected characters come from predict_text
    task automatic send_value(input logic [63:0] v, input string text);
        int  i;
        byte ch;
        if (!steady)
            while ($urandom_range(0, 99) < 23)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (text.len() == 0)
            predict_text(v);
        else
            for (i = 0; i < text.len(); i++)
            begin
                ch = text[i];
                queue_char(ch[i2rs_pkg::CHAR_W-1:0], i == text.len() - 1);
            end
        numbers_sent++;
    endtask

    // Hold off the sender until every pending character has been seen or DRAIN_LIMIT runs out
    task automatic drain_results();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (pending_chars.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_chars.size() != 0)
        begin
            note_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
            pending_chars.delete();
        end
    endtask

    task automatic set_radix(input logic [i2rs_pkg::RADIX_W-1:0] r);
        radix_we    <= 1'b1;
        radix_wdata <= r;
        @(posedge clk);
        radix_we  <= 1'b0;
        radix_now = r;
        radix_writes++;
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] raw;
        int          width;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:
                raw = 64'($urandom_range(0, 99));
            1:
                ;
            default:
            begin
                width = $urandom_range(1, 63);
                raw = raw & ((64'd1 << width) - 64'd1);
                if ($urandom_range(0, 1))
                    raw = ~raw + 64'd1;
            end
        endcase
        return raw;
    endfunction

    always @(posedge clk)
    begin
        char_beat_t want;
        if (rst_n && strobe)
        begin
            chars_seen++;
            if (pending_chars.size() == 0)
                note_mismatch($sformatf("unexpected character 0x%02h last=%0b", character, last));
            else
            begin
                want = pending_chars.pop_front();
                if (character !== want.code)
                    note_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
                                            character, want.code));
                if (last !== want.fin)
                    note_mismatch($sformatf("last %0b, wanted %0b on character 0x%02h",
                                            last, want.fin, want.code));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("integer_to_radix_string: mismatch");
        $finish;
    end

    initial
    begin
        int                           r;
        int                           p;
        int                           k;
        logic [i2rs_pkg::RADIX_W-1:0] phase_radix;

        // reset radix of 10 is used without a write
        add_row(7'd10,  64'd0, "0");
        add_row(7'd10,  64'd1, "1");
        add_row(7'd10, -64'sd1, "-1");
        add_row(7'd10,  MAG_LIMIT, "9223372036854775807");
        add_row(7'd10, -64'sd9223372036854775807, "-9223372036854775807");
        add_row(7'd10,  64'h8000_0000_0000_0000, "-9223372036854775807");
        add_row(7'd10,  64'd12345, "");
        add_row(7'd16,  64'd255, "ff");
        add_row(7'd16,  MAG_LIMIT, "7fffffffffffffff");
        add_row(7'd2,   64'd5, "101");
        add_row(7'd2,   MAG_LIMIT, "");
        add_row(7'd2,   64'h8000_0000_0000_0000, "");
        add_row(7'd0,   64'd6, "110");
        add_row(7'd1,  -64'sd2, "-10");
        add_row(7'd85,  64'd84, "[");
        add_row(7'd85,  64'd85, "10");
        add_row(7'd85,  64'd7224, "[[");
        add_row(7'd85,  MAG_LIMIT, "");
        add_row(7'd86,  64'd84, "[");
        add_row(7'd127, -64'sd84, "-[");
        add_row(7'd62,  64'd61, "Z");
        add_row(7'd63,  64'd62, "!");
        add_row(7'd64,  64'd63, "\"");
        add_row(7'd36,  64'd35, "z");
        add_row(7'd37,  64'd36, "A");
        add_row(7'd80,  64'd6157, "/:");

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < row_value.size(); r++)
        begin
            if (row_radix[r] != radix_now)
            begin
                drain_results();
                set_radix(row_radix[r]);
            end
            send_value(row_value[r], row_text[r]);
        end

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: phase_radix = 7'd2;
                1: phase_radix = 7'd85;
                2: phase_radix = 7'd127;
                3: phase_radix = 7'd0;
                4: phase_radix = 7'd36;
                5: phase_radix = 7'd16;
                6: phase_radix = i2rs_pkg::RADIX_W'($urandom_range(2, 85));
                default: phase_radix = i2rs_pkg::RADIX_W'($urandom_range(0, 127));
            endcase
            drain_results();
            set_radix(phase_radix);
            // one phase runs back to back with no sender gaps
            steady = (p == 5);
            for (k = 0; k < PHASE_ITEMS; k++)
                send_value(random_value(), "");
        end
        steady = 1'b0;

        drain_results();
        repeat (20) @(posedge clk);

        $display("Converted %0d numbers into %0d characters over %0d radix writes",
                 numbers_sent, chars_seen, radix_writes);
        $display("Radix settings spanned 0 through 127, signs and magnitude extremes, %0d cycles",
                 cycle_count);
        if (mismatches == 0)
            $display("integer_to_radix_string: match");
        else
            $display("integer_to_radix_string: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/i2rs_pkg.sv
hdl/i2rs_front.sv
hdl/i2rs_fifo.sv
hdl/i2rs_div.sv
hdl/i2rs_back.sv
hdl/integer_to_radix_string.sv
bench/testbench.sv
